@@ design/assert_macros.svh @@
// assertion macros used by the top-level design file
// expects a clock i_clk and an active-low reset i_rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define MRPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked every clock
`define MRPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/mrpt_pkg.sv @@
// shared types, constants and the small prime table of the primality tester
// no dependencies
package mrpt_pkg;

    localparam int CAND_W            = 63;
    localparam int WORD_W            = 64;
    localparam int SMALL_PRIME_COUNT = 12;
    localparam int WITNESS_COUNT_DEF = 12;
    localparam int SMALL_LIMIT       = 41 * 41;
    localparam int RECIP_SHIFT       = 20;

    typedef enum logic [3:0] {
        S_IDLE, S_TRIAL, S_CLASS, S_DECOMP, S_NINV_A, S_NINV_B, S_RMOD,
        S_WBASE, S_WLOOP, S_WMUL, S_WSQ, S_WCHK, S_WSQR, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE, M_AB, M_M, M_MN, M_FIN
    } t_mont_state;

    typedef struct packed {
        logic start;
        logic low;
    } t_mont_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_mont_rsp;

    // first twelve primes
    function automatic logic [5:0] small_prime(input logic [3:0] idx);
        logic [5:0] p;
        unique case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd0;
        endcase
        return p;
    endfunction

    // ceil(2^20 / p), gives the exact quotient for dividends below 2^14
    function automatic logic [19:0] small_recip(input logic [3:0] idx);
        logic [19:0] m;
        unique case (idx)
            4'd0:    m = 20'd524288;
            4'd1:    m = 20'd349526;
            4'd2:    m = 20'd209716;
            4'd3:    m = 20'd149797;
            4'd4:    m = 20'd95326;
            4'd5:    m = 20'd80660;
            4'd6:    m = 20'd61681;
            4'd7:    m = 20'd55189;
            4'd8:    m = 20'd45591;
            4'd9:    m = 20'd36158;
            4'd10:   m = 20'd33826;
            4'd11:   m = 20'd28340;
            default: m = 20'd0;
        endcase
        return m;
    endfunction

endpackage

@@ design/mrpt_mul.sv @@
// iterative 64x64 multiplier, one 32x32 partial product per cycle
// depends on mrpt_pkg
module mrpt_mul import mrpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_W-1:0]     i_a,
    input  logic [WORD_W-1:0]     i_b,
    output logic                  o_done,
    output logic [2*WORD_W-1:0]   o_prod
);

    logic [WORD_W-1:0]   r_a, n_a, r_b, n_b;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_busy, n_busy, r_pv, n_pv, r_done, n_done;
    logic [WORD_W-1:0]   r_pp, n_pp;
    logic [1:0]          r_sh, n_sh;
    logic [2*WORD_W-1:0] r_acc, n_acc;
    logic [31:0]         ai, bi;

    // partial product select, then accumulate the previous one
    always_comb begin
        n_a = r_a; n_b = r_b; n_cnt = r_cnt; n_busy = r_busy; n_pv = r_pv;
        n_pp = r_pp; n_sh = r_sh; n_acc = r_acc; n_done = 1'b0;
        ai = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        bi = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        if (i_start) begin
            n_a = i_a; n_b = i_b; n_cnt = 3'd0; n_busy = 1'b1;
            n_acc = '0; n_pv = 1'b0;
        end else if (r_busy) begin
            if (r_pv) begin
                n_acc = r_acc + ({64'd0, r_pp} << {r_sh, 5'd0});
            end
            if (r_cnt < 3'd4) begin
                n_pp  = {32'd0, ai} * {32'd0, bi};
                n_sh  = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
                n_pv  = 1'b1;
                n_cnt = r_cnt + 3'd1;
            end else begin
                n_busy = 1'b0; n_pv = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pv <= 1'b0; r_done <= 1'b0; r_cnt <= 3'd0;
        end else begin
            r_busy <= n_busy; r_pv <= n_pv; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_a <= n_a; r_b <= n_b; r_pp <= n_pp; r_sh <= n_sh; r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ design/mrpt_mont.sv @@
// montgomery product unit (R = 2^64) with a plain low-product mode
// depends on mrpt_pkg and mrpt_mul
module mrpt_mont import mrpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mont_req         i_req,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    input  logic [WORD_W-1:0] i_n,
    input  logic [WORD_W-1:0] i_ninv,
    output t_mont_rsp         o_rsp,
    output logic [WORD_W-1:0] o_res
);

    t_mont_state         r_state, n_state;
    logic                r_low, n_low, r_done, n_done;
    logic [WORD_W-1:0]   r_lo, n_lo, r_hi, n_hi, r_t, n_t, r_res, n_res;
    logic                mul_start, mul_done;
    logic [WORD_W-1:0]   mul_a, mul_b;
    logic [2*WORD_W-1:0] mul_p;

    mrpt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_done <= n_done;
        end
        r_low <= n_low; r_lo <= n_lo; r_hi <= n_hi; r_t <= n_t; r_res <= n_res;
    end

    // a*b, then m = lo*ninv, then high(m*n) folded in, then final subtract
    always_comb begin
        n_state = r_state; n_low = r_low; n_lo = r_lo; n_hi = r_hi;
        n_t = r_t; n_res = r_res; n_done = 1'b0;
        mul_start = 1'b0; mul_a = i_a; mul_b = i_b;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    mul_start = 1'b1; n_low = i_req.low; n_state = M_AB;
                end
            end
            M_AB: begin
                if (mul_done) begin
                    n_lo = mul_p[63:0]; n_hi = mul_p[127:64];
                    if (r_low) begin
                        n_res = mul_p[63:0]; n_done = 1'b1; n_state = M_IDLE;
                    end else begin
                        mul_start = 1'b1; mul_a = mul_p[63:0]; mul_b = i_ninv;
                        n_state = M_M;
                    end
                end
            end
            M_M: begin
                if (mul_done) begin
                    mul_start = 1'b1; mul_a = mul_p[63:0]; mul_b = i_n;
                    n_state = M_MN;
                end
            end
            M_MN: begin
                if (mul_done) begin
                    n_t = r_hi + mul_p[127:64] + {63'd0, (r_lo != '0)};
                    n_state = M_FIN;
                end
            end
            M_FIN: begin
                n_res = (r_t >= i_n) ? r_t - i_n : r_t;
                n_done = 1'b1; n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_state != M_IDLE);
    assign o_res      = r_res;

endmodule

@@ design/mrpt_trial.sv @@
// remainders of the candidate by the twelve small primes, one byte per cycle
// depends on mrpt_pkg
module mrpt_trial import mrpt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [CAND_W-1:0]            i_n,
    output logic                         o_done,
    output logic [SMALL_PRIME_COUNT-1:0] o_div
);

    logic [WORD_W-1:0] r_sh, n_sh;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;
    logic [5:0]        r_rem [SMALL_PRIME_COUNT];
    logic [5:0]        n_rem [SMALL_PRIME_COUNT];
    logic [13:0]       v     [SMALL_PRIME_COUNT];
    logic [33:0]       qm    [SMALL_PRIME_COUNT];
    logic [13:0]       q     [SMALL_PRIME_COUNT];
    logic [13:0]       qp    [SMALL_PRIME_COUNT];

    // rem*256 + next byte, reduced by reciprocal quotient, msb byte first
    always_comb begin
        n_sh = r_sh; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        for (int i = 0; i < SMALL_PRIME_COUNT; i++) begin
            v[i]     = {r_rem[i], r_sh[WORD_W-1 -: 8]};
            qm[i]    = 34'(v[i]) * 34'(small_recip(4'(i)));
            q[i]     = qm[i][RECIP_SHIFT +: 14];
            qp[i]    = q[i] * {8'd0, small_prime(4'(i))};
            n_rem[i] = r_rem[i];
        end
        if (i_start) begin
            n_sh = {1'b0, i_n}; n_cnt = '0; n_busy = 1'b1;
            for (int i = 0; i < SMALL_PRIME_COUNT; i++) n_rem[i] = '0;
        end else if (r_busy) begin
            for (int i = 0; i < SMALL_PRIME_COUNT; i++) begin
                n_rem[i] = 6'(v[i] - qp[i]);
            end
            n_sh  = r_sh << 8;
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_sh <= n_sh;
        for (int i = 0; i < SMALL_PRIME_COUNT; i++) r_rem[i] <= n_rem[i];
    end

    always_comb begin
        for (int i = 0; i < SMALL_PRIME_COUNT; i++) o_div[i] = (r_rem[i] == 6'd0);
    end
    assign o_done = r_done;

endmodule

@@ design/miller_rabin_prime_test.sv @@
// Deterministic primality test for candidates below 2^63, one item at a time.
// A transfer in is taken only while the block is idle; the result waits in an
// output register so the next candidate can be taken meanwhile. Values
// rejected or settled by the small primes finish after trial division, one
// byte per cycle; larger values add the 2-adic split (one step per trailing
// zero of n-1, plus one), 12 low products for the inverse, doublings for R mod
// n and R^2 mod n, and per witness up to bits(d) + popcount(d) + s montgomery
// products, all on the one shared 32x32 multiplier.
// depends on mrpt_pkg, mrpt_trial, mrpt_mont, assert_macros.svh
`include "assert_macros.svh"
module miller_rabin_prime_test import mrpt_pkg::*; #(
    parameter int WITNESS_COUNT = WITNESS_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CAND_W-1:0] i_candidate,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_prime_flag
);

    t_state            r_state, n_state;
    logic              r_go, n_go, r_flag, n_flag, r_ovalid, n_ovalid, r_oflag, n_oflag;
    logic [WORD_W-1:0] r_n, n_n, r_d, n_d, r_x, n_x, r_t, n_t, r_ninv, n_ninv;
    logic [WORD_W-1:0] r_one, n_one, r_r2, n_r2, r_nm1, n_nm1;
    logic [WORD_W-1:0] r_base, n_base, r_wx, n_wx, r_e, n_e;
    logic [5:0]        r_s, n_s;
    logic [6:0]        r_cnt, n_cnt;
    logic [3:0]        r_wi, n_wi;

    logic                         trial_start, trial_done;
    logic [SMALL_PRIME_COUNT-1:0] trial_div;
    t_mont_req                    mreq;
    t_mont_rsp                    mrsp;
    logic [WORD_W-1:0]            m_a, m_b, m_res, dbl;
    logic                         is_small, last_w;

    mrpt_trial u_trial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trial_start),
        .i_n     (i_candidate),
        .o_done  (trial_done),
        .o_div   (trial_div)
    );

    mrpt_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .i_a     (m_a),
        .i_b     (m_b),
        .i_n     (r_n),
        .i_ninv  (r_ninv),
        .o_rsp   (mrsp),
        .o_res   (m_res)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign trial_start  = i_valid && o_ready;
    assign o_valid      = r_ovalid;
    assign o_prime_flag = r_oflag;
    assign last_w       = (r_wi == 4'(WITNESS_COUNT - 1));

    // candidate equals one of the small primes
    always_comb begin
        is_small = 1'b0;
        for (int i = 0; i < SMALL_PRIME_COUNT; i++) begin
            if (r_n == {58'd0, small_prime(4'(i))}) is_small = 1'b1;
        end
    end

    // doubling step for R mod n and R^2 mod n
    always_comb begin
        dbl = {r_r2[62:0], 1'b0};
        if (dbl >= r_n) dbl = dbl - r_n;
    end

    // operand select for the shared product unit
    always_comb begin
        mreq.start = r_go;
        mreq.low   = (r_state == S_NINV_A) || (r_state == S_NINV_B);
        m_a = '0; m_b = '0;
        unique case (r_state)
            S_NINV_A: begin m_a = r_n;    m_b = r_x; end
            S_NINV_B: begin m_a = r_x;    m_b = 64'd2 - r_t; end
            S_WBASE:  begin m_a = {58'd0, small_prime(r_wi)}; m_b = r_r2; end
            S_WMUL:   begin m_a = r_wx;   m_b = r_base; end
            S_WSQ:    begin m_a = r_base; m_b = r_base; end
            S_WSQR:   begin m_a = r_wx;   m_b = r_wx; end
            default:  begin m_a = '0;     m_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_go <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_go <= n_go; r_ovalid <= n_ovalid;
        end
        r_flag <= n_flag; r_oflag <= n_oflag; r_n <= n_n; r_d <= n_d;
        r_x <= n_x; r_t <= n_t; r_ninv <= n_ninv; r_one <= n_one;
        r_r2 <= n_r2; r_nm1 <= n_nm1; r_base <= n_base; r_wx <= n_wx;
        r_e <= n_e; r_s <= n_s; r_cnt <= n_cnt; r_wi <= n_wi;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_go = 1'b0; n_flag = r_flag; n_oflag = r_oflag;
        n_ovalid = r_ovalid && !i_ready;
        n_n = r_n; n_d = r_d; n_x = r_x; n_t = r_t; n_ninv = r_ninv;
        n_one = r_one; n_r2 = r_r2; n_nm1 = r_nm1; n_base = r_base;
        n_wx = r_wx; n_e = r_e; n_s = r_s; n_cnt = r_cnt; n_wi = r_wi;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n = {1'b0, i_candidate}; n_state = S_TRIAL;
                end
            end
            S_TRIAL: begin
                if (trial_done) n_state = S_CLASS;
            end
            S_CLASS: begin
                priority if (r_n < 64'd2) begin
                    n_flag = 1'b0; n_state = S_OUT;
                end else if (|trial_div) begin
                    n_flag = is_small; n_state = S_OUT;
                end else if (r_n < 64'(SMALL_LIMIT)) begin
                    n_flag = 1'b1; n_state = S_OUT;
                end else begin
                    n_d = r_n - 64'd1; n_s = '0; n_state = S_DECOMP;
                end
            end
            S_DECOMP: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1; n_s = r_s + 6'd1;
                end else begin
                    n_x = r_n; n_cnt = '0; n_go = 1'b1; n_state = S_NINV_A;
                end
            end
            S_NINV_A: begin
                if (mrsp.done) begin
                    n_t = m_res; n_go = 1'b1; n_state = S_NINV_B;
                end
            end
            S_NINV_B: begin
                if (mrsp.done) begin
                    n_x = m_res;
                    if (r_cnt == 7'd5) begin
                        n_ninv = 64'd0 - m_res; n_r2 = 64'd1; n_cnt = '0;
                        n_state = S_RMOD;
                    end else begin
                        n_cnt = r_cnt + 7'd1; n_go = 1'b1; n_state = S_NINV_A;
                    end
                end
            end
            S_RMOD: begin
                n_r2  = dbl;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) n_one = dbl;
                if (r_cnt == 7'd127) begin
                    n_nm1 = r_n - r_one; n_wi = '0; n_go = 1'b1; n_state = S_WBASE;
                end
            end
            S_WBASE: begin
                if (mrsp.done) begin
                    n_base = m_res; n_wx = r_one; n_e = r_d; n_state = S_WLOOP;
                end
            end
            S_WLOOP: begin
                if (r_e == '0) begin
                    n_state = S_WCHK;
                end else begin
                    n_go = 1'b1; n_state = r_e[0] ? S_WMUL : S_WSQ;
                end
            end
            S_WMUL: begin
                if (mrsp.done) begin
                    n_wx = m_res; n_go = 1'b1; n_state = S_WSQ;
                end
            end
            S_WSQ: begin
                if (mrsp.done) begin
                    n_base = m_res; n_e = r_e >> 1; n_state = S_WLOOP;
                end
            end
            S_WCHK: begin
                priority if (r_wx == r_one || r_wx == r_nm1) begin
                    if (last_w) begin
                        n_flag = 1'b1; n_state = S_OUT;
                    end else begin
                        n_wi = r_wi + 4'd1; n_go = 1'b1; n_state = S_WBASE;
                    end
                end else if (r_s > 6'd1) begin
                    n_cnt = '0; n_go = 1'b1; n_state = S_WSQR;
                end else begin
                    n_flag = 1'b0; n_state = S_OUT;
                end
            end
            S_WSQR: begin
                if (mrsp.done) begin
                    n_wx = m_res;
                    priority if (m_res == r_nm1) begin
                        if (last_w) begin
                            n_flag = 1'b1; n_state = S_OUT;
                        end else begin
                            n_wi = r_wi + 4'd1; n_go = 1'b1; n_state = S_WBASE;
                        end
                    end else if ((r_cnt + 7'd2) < {1'b0, r_s}) begin
                        n_cnt = r_cnt + 7'd1; n_go = 1'b1;
                    end else begin
                        n_flag = 1'b0; n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1; n_oflag = r_flag; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // checks on the sequencer
    `MRPT_ASSERT_IMP(a_go_idle, r_go, !mrsp.busy, "product start while unit busy")
    `MRPT_ASSERT_IMP(a_wx_range, r_state == S_WLOOP, (r_wx < r_n) && (r_base < r_n),
        "witness value out of range")
    `MRPT_ASSERT_IMP(a_decomp_nz, r_state == S_DECOMP, r_d != '0, "zero odd part")
    `MRPT_ASSERT(a_one_range, (r_state == S_WBASE) |-> (r_one < r_n), "R mod n too large")

endmodule
